/* rtl/core/rft_pkg.sv */
package rft_pkg;

  localparam int unsigned IdxW    = 10;
  localparam int unsigned SampleW = 16;
  localparam int unsigned BinW    = 27;
  localparam int unsigned WordW   = 28;
  localparam int unsigned TwW     = 19;

  typedef enum logic [1:0] {
    FUNC_STORE = 2'd0,
    FUNC_XFORM = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_STORED = 2'd0,
    STAT_DONE   = 2'd1,
    STAT_READ   = 2'd2,
    STAT_RSVD   = 2'd3
  } status_e;

endpackage

/* rtl/core/rft_in_if.sv */
interface rft_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           func;
  logic [rft_pkg::IdxW-1:0]             index;
  logic signed [rft_pkg::SampleW-1:0]   sample_real;
  logic signed [rft_pkg::SampleW-1:0]   sample_imag;

  modport source (output valid, func, index, sample_real, sample_imag, input ready);
  modport sink   (input valid, func, index, sample_real, sample_imag, output ready);
endinterface

/* rtl/core/rft_out_if.sv */
interface rft_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rft_pkg::BinW-1:0]   bin_real;
  logic signed [rft_pkg::BinW-1:0]   bin_imag;
  logic [1:0]                        status;

  modport source (output valid, bin_real, bin_imag, status, input ready);
  modport sink   (input valid, bin_real, bin_imag, status, output ready);
endinterface

/* rtl/core/radix2_fft_in_place_top.sv */
// in-place radix-2 decimation-in-time fft over a frame of POINTS complex words.
// in_i takes one item per command: store a sample at index, run the transform,
// or read a bin at index (index wraps at POINTS). out_o returns one item per
// store, transform or read with a status code; bin fields are zero unless reading.
// the fourth command code is taken with no result. a read passes through a
//   read-out state; a transform runs bit-reversal swaps, then the butterfly
//   stages, paced by the frame memory with one read and one write port (two
//   reads and two writes per word pair) and one shared 19x28 multiplier used
//   four times per butterfly.
// the block takes one item at a time; in_i.ready is high only when idle and
// the output register is empty or being drained in the same cycle.
// when the receiver stalls, the result waits in the output register and no
// new item is taken. reset clears the control and the output valid; the
// frame memory keeps no reset value and must be written before use.
// twiddles are built at elaboration into a rom of POINTS/2 entries.
module radix2_fft_in_place_top #(
  parameter int unsigned POINTS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rft_in_if.sink     in_i,
  rft_out_if.source  out_o
);

  localparam int unsigned AW  = $clog2(POINTS);
  localparam int unsigned HW  = AW - 1;
  localparam int unsigned SW  = $clog2(AW + 1);
  localparam int unsigned WW  = rft_pkg::WordW;
  localparam int unsigned TW  = rft_pkg::TwW;
  localparam int unsigned PW  = TW + WW;
  localparam int unsigned ACW = PW + 1;
  localparam longint unsigned PIQ30  = 64'd3373259426;
  localparam longint signed   ONEQ30 = 64'sd1073741824;

  typedef logic [2*TW-1:0] tw_rom_t [POINTS/2];

  typedef enum logic [3:0] {
    S_IDLE, S_RDOUT, S_RA, S_RB, S_RC, S_MUL, S_WA, S_WB, S_DONE
  } state_e;

  // ---------------- twiddle rom built at elaboration ----------------
  // reciprocals ceil(2^39/d) of the taylor divisors
  function automatic longint unsigned sin_recip(int k);
    longint unsigned d;
    case (k)
      1:       d = 64'd91625968982;
      2:       d = 64'd27487790695;
      3:       d = 64'd13089424141;
      default: d = 64'd7635497416;
    endcase
    return d;
  endfunction

  function automatic longint unsigned cos_recip(int k);
    longint unsigned d;
    case (k)
      1:       d = 64'd274877906944;
      2:       d = 64'd45812984491;
      3:       d = 64'd18325193797;
      4:       d = 64'd9817068106;
      default: d = 64'd6108397933;
    endcase
    return d;
  endfunction

  // exact floor of x/d for x below 2^32
  function automatic longint unsigned div_recip(longint unsigned x, longint unsigned recip);
    logic [79:0] p;
    p = 80'(x) * 80'(recip);
    return 64'(p >> 39);
  endfunction

  function automatic longint signed to_q17(longint signed sum);
    longint signed v;
    v = (sum < 0) ? 64'sd0 : sum;
    return (v + 64'sd4096) >>> 13;
  endfunction

  // returns {cos, sin} for angle 2*pi*m/POINTS, m up to POINTS/8
  function automatic logic [63:0] octant_cs(longint unsigned m);
    longint unsigned th;
    longint unsigned th2;
    longint unsigned term;
    longint signed   sum;
    longint signed   s;
    longint signed   c;
    th   = (PIQ30 * 64'd2 * m + 64'(POINTS / 2)) >> AW;
    th2  = (th * th) >> 30;
    term = th;
    sum  = longint'(th);
    for (int k = 1; k <= 4; k++) begin
      term = div_recip((term * th2) >> 30, sin_recip(k));
      sum  = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
    end
    s    = to_q17(sum);
    term = 64'(ONEQ30);
    sum  = ONEQ30;
    for (int k = 1; k <= 5; k++) begin
      term = div_recip((term * th2) >> 30, cos_recip(k));
      sum  = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
    end
    c = to_q17(sum);
    return {c[31:0], s[31:0]};
  endfunction

  function automatic logic [63:0] quarter_cs(longint unsigned m);
    longint unsigned q;
    logic [63:0]     r;
    q = 64'(POINTS / 4);
    if (m <= q / 2) begin
      r = octant_cs(m);
    end else begin
      r = octant_cs(q - m);
      r = {r[31:0], r[63:32]};
    end
    return r;
  endfunction

  function automatic tw_rom_t build_tw();
    tw_rom_t         rom;
    longint unsigned q;
    logic [63:0]     cs;
    logic signed [31:0] c;
    logic signed [31:0] s;
    q = 64'(POINTS / 4);
    for (int m = 0; m < POINTS / 2; m++) begin
      if (64'(m) <= q) begin
        cs = quarter_cs(64'(m));
        c  = cs[63:32];
        s  = cs[31:0];
      end else begin
        cs = quarter_cs(64'(m) - q);
        c  = -$signed(cs[31:0]);
        s  = cs[63:32];
      end
      rom[m] = {c[TW-1:0], TW'(-s)};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_tw();

  function automatic logic [AW-1:0] bit_rev(logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) r[b] = v[AW-1-b];
    return r;
  endfunction

  function automatic logic signed [WW-1:0] sat_word(logic signed [WW+3:0] v);
    logic signed [WW+3:0] hi;
    logic signed [WW+3:0] lo;
    hi = (WW+4)'({1'b0, {(WW-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) return hi[WW-1:0];
    if (v < lo) return lo[WW-1:0];
    return v[WW-1:0];
  endfunction

  function automatic logic signed [rft_pkg::BinW-1:0] sat_bin(logic signed [WW-1:0] v);
    if (v[WW-1] != v[WW-2]) begin
      return v[WW-1] ? {1'b1, {(rft_pkg::BinW-1){1'b0}}} : {1'b0, {(rft_pkg::BinW-1){1'b1}}};
    end
    return v[rft_pkg::BinW-1:0];
  endfunction

  // ---------------- control registers ----------------
  state_e         state_q, state_d;
  logic           bf_q, bf_d;          // butterfly phase, else bit reversal
  logic [AW-1:0]  i_q, i_d;
  logic [HW-1:0]  j_q, j_d;
  logic [SW-1:0]  s_q, s_d;
  logic [2:0]     mc_q, mc_d;
  logic           out_valid_q, out_valid_d;
  logic [1:0]     status_q, status_d;
  logic           ld_zero, ld_read;

  // ---------------- datapath ----------------
  logic [2*WW-1:0]        mem [POINTS];
  logic [2*WW-1:0]        rdata_q;
  logic [2*TW-1:0]        tw_q;
  logic signed [WW-1:0]   xar_q, xai_q, xbr_q, xbi_q, ybr_q, ybi_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [ACW-1:0]  acc_re_q, acc_im_q;
  logic signed [rft_pkg::BinW-1:0] bin_re_q, bin_im_q;

  logic                   accept;
  logic [AW-1:0]          idx;
  logic [HW-1:0]          hmask, kk, tw_addr;
  logic [AW-1:0]          half, pa, pb, raddr, waddr;
  logic                   we, swap;
  logic [2*WW-1:0]        wdata;
  logic signed [TW-1:0]   wr, wi, op_w;
  logic signed [WW-1:0]   op_x;
  logic signed [WW+2:0]   tr, ti;
  logic signed [WW-1:0]   yar, yai;

  assign accept = in_i.valid && in_i.ready;
  assign idx    = AW'(in_i.index);
  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);

  assign half    = AW'(1) << (s_q - SW'(1));
  assign hmask   = HW'(half - AW'(1));
  assign kk      = j_q & hmask;
  assign tw_addr = kk << (SW'(AW) - s_q);
  assign pa      = bf_q ? ({j_q & ~hmask, 1'b0} | AW'(kk)) : i_q;
  assign pb      = bf_q ? (pa | half) : bit_rev(i_q);
  assign swap    = i_q < bit_rev(i_q);

  assign wr = tw_q[2*TW-1:TW];
  assign wi = tw_q[TW-1:0];

  always_comb begin
    unique case (mc_q)
      3'd0:    begin op_w = wr; op_x = xbr_q; end
      3'd1:    begin op_w = wi; op_x = xbi_q; end
      3'd2:    begin op_w = wr; op_x = xbi_q; end
      default: begin op_w = wi; op_x = xbr_q; end
    endcase
  end

  // round to nearest, ties upward
  assign tr  = (WW+3)'((acc_re_q + ACW'(65536)) >>> 17);
  assign ti  = (WW+3)'((acc_im_q + ACW'(65536)) >>> 17);
  assign yar = bf_q ? sat_word((WW+4)'(xar_q) + (WW+4)'(tr)) : (swap ? xbr_q : xar_q);
  assign yai = bf_q ? sat_word((WW+4)'(xai_q) + (WW+4)'(ti)) : (swap ? xbi_q : xai_q);

  always_comb begin
    raddr = idx;
    we    = 1'b0;
    waddr = pa;
    wdata = {yar, yai};
    unique case (state_q)
      S_IDLE: begin
        we    = accept && (in_i.func == rft_pkg::FUNC_STORE);
        waddr = idx;
        wdata = {WW'(in_i.sample_real), WW'(in_i.sample_imag)};
      end
      S_RA: raddr = pa;
      S_RB: raddr = pb;
      S_WA: we = 1'b1;
      S_WB: begin
        we    = 1'b1;
        waddr = pb;
        wdata = {ybr_q, ybi_q};
      end
      default: raddr = pa;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
    tw_q    <= TW_ROM[tw_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RB) {xar_q, xai_q} <= rdata_q;
    if (state_q == S_RC) {xbr_q, xbi_q} <= rdata_q;
    if (state_q == S_MUL) begin
      prod_q <= PW'(op_w * op_x);
      unique case (mc_q)
        3'd1:    acc_re_q <= ACW'(prod_q);
        3'd2:    acc_re_q <= acc_re_q - ACW'(prod_q);
        3'd3:    acc_im_q <= ACW'(prod_q);
        3'd4:    acc_im_q <= acc_im_q + ACW'(prod_q);
        default: acc_re_q <= acc_re_q;
      endcase
    end
    if (state_q == S_WA) begin
      ybr_q <= bf_q ? sat_word((WW+4)'(xar_q) - (WW+4)'(tr)) : (swap ? xar_q : xbr_q);
      ybi_q <= bf_q ? sat_word((WW+4)'(xai_q) - (WW+4)'(ti)) : (swap ? xai_q : xbi_q);
    end
    if (ld_zero) begin
      bin_re_q <= '0;
      bin_im_q <= '0;
    end else if (ld_read) begin
      bin_re_q <= sat_bin(rdata_q[2*WW-1:WW]);
      bin_im_q <= sat_bin(rdata_q[WW-1:0]);
    end
  end

  always_comb begin
    state_d     = state_q;
    bf_d        = bf_q;
    i_d         = i_q;
    j_d         = j_q;
    s_d         = s_q;
    mc_d        = mc_q;
    out_valid_d = out_valid_q && !out_o.ready;
    status_d    = status_q;
    ld_zero     = 1'b0;
    ld_read     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_i.func)
            rft_pkg::FUNC_STORE: begin
              out_valid_d = 1'b1;
              status_d    = rft_pkg::STAT_STORED;
              ld_zero     = 1'b1;
            end
            rft_pkg::FUNC_XFORM: begin
              state_d = S_RA;
              bf_d    = 1'b0;
              i_d     = '0;
            end
            rft_pkg::FUNC_READ: state_d = S_RDOUT;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RDOUT: begin
        out_valid_d = 1'b1;
        status_d    = rft_pkg::STAT_READ;
        ld_read     = 1'b1;
        state_d     = S_IDLE;
      end
      S_RA: state_d = S_RB;
      S_RB: state_d = S_RC;
      S_RC: begin
        mc_d    = '0;
        state_d = bf_q ? S_MUL : S_WA;
      end
      S_MUL: begin
        mc_d = mc_q + 3'd1;
        if (mc_q == 3'd4) state_d = S_WA;
      end
      S_WA: state_d = S_WB;
      S_WB: begin
        state_d = S_RA;
        if (!bf_q) begin
          if (i_q == '1) begin
            bf_d = 1'b1;
            s_d  = SW'(1);
            j_d  = '0;
          end else begin
            i_d = i_q + AW'(1);
          end
        end else if (j_q == '1) begin
          j_d = '0;
          if (s_q == SW'(AW)) state_d = S_DONE;
          else s_d = s_q + SW'(1);
        end else begin
          j_d = j_q + HW'(1);
        end
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        status_d    = rft_pkg::STAT_DONE;
        ld_zero     = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bf_q        <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      s_q         <= SW'(1);
      mc_q        <= '0;
      out_valid_q <= 1'b0;
      status_q    <= rft_pkg::STAT_STORED;
    end else begin
      state_q     <= state_d;
      bf_q        <= bf_d;
      i_q         <= i_d;
      j_q         <= j_d;
      s_q         <= s_d;
      mc_q        <= mc_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.bin_real = bin_re_q;
  assign out_o.bin_imag = bin_im_q;
  assign out_o.status   = status_q;

  // no new item while the transform or a read is in progress
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_i.ready)
    else $error("item taken while busy");

  // a result appears only from an idle accept, a finished read or a finished transform
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_IDLE || $past(state_q) == S_RDOUT
                            || $past(state_q) == S_DONE))
    else $error("result without a cause");

  // butterfly partners are always half a span apart
  a_pair_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && bf_q) |-> (pb - pa == half))
    else $error("butterfly pair addresses broken");

endmodule

/* sim/tb_radix2_fft_in_place_top.sv */
module tb_radix2_fft_in_place_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPts = 1024;
  localparam int unsigned LgPts = 10;
  localparam int unsigned BinBits = rft_pkg::BinW;
  localparam int unsigned SmpBits = rft_pkg::SampleW;
  localparam longint unsigned PiQ30 = 64'd3373259426;
  localparam longint OneQ30 = 64'sd1073741824;

  typedef struct {
    logic signed [rft_pkg::BinW-1:0] re;
    logic signed [rft_pkg::BinW-1:0] im;
    rft_pkg::status_e                st;
  } bin_t;

  logic clk_i;
  logic rst_ni;
  rft_in_if  in_if ();
  rft_out_if out_if ();

  radix2_fft_in_place_top #(.POINTS(NPts)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  longint frame_re [NPts];
  longint frame_im [NPts];
  longint rom_re [NPts/2];
  longint rom_im [NPts/2];
  bit     written [NPts];
  bin_t   bin_q [$];
  int     n_err;
  int     quiet_in;
  int     quiet_out;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    n_err++;
  endtask

  function automatic longint q30_to_q17(input longint acc);
    if (acc < 0) acc = 0;
    return (acc + 4096) >>> 13;
  endfunction

  // sin/cos by taylor series for angles up to pi/4
  function automatic void octant_sincos(input longint unsigned m, output longint c,
                                        output longint s);
    longint unsigned th, th2, term;
    longint acc;
    th = (PiQ30 * 2 * m + NPts / 2) / NPts;
    th2 = (th * th) >> 30;
    term = th;
    acc = longint'(th);
    for (int k = 1; k <= 4; k++) begin
      term = ((term * th2) >> 30) / longint'((2 * k) * (2 * k + 1));
      acc += (k & 1) ? -longint'(term) : longint'(term);
    end
    s = q30_to_q17(acc);
    term = OneQ30;
    acc = OneQ30;
    for (int k = 1; k <= 5; k++) begin
      term = ((term * th2) >> 30) / longint'((2 * k - 1) * (2 * k));
      acc += (k & 1) ? -longint'(term) : longint'(term);
    end
    c = q30_to_q17(acc);
  endfunction

  function automatic void quarter_sincos(input longint unsigned m, output longint c,
                                         output longint s);
    if (m <= NPts / 8) octant_sincos(m, c, s);
    else octant_sincos(NPts / 4 - m, s, c);
  endfunction

  function automatic void build_twiddle_rom();
    longint c, s, c2, s2;
    for (int m = 0; m < NPts / 2; m++) begin
      if (m <= NPts / 4) begin
        quarter_sincos(m, c, s);
      end else begin
        quarter_sincos(m - NPts / 4, c2, s2);
        c = -s2;
        s = c2;
      end
      rom_re[m] = c;
      rom_im[m] = -s;
    end
  endfunction

  function automatic longint clip(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic void fft_frame();
    int r, v, a, b, w;
    longint tmp, xr, xi, tr, ti, ar, ai;
    for (int i = 0; i < NPts; i++) begin
      r = 0;
      v = i;
      for (int k = 0; k < LgPts; k++) begin
        r = (r << 1) | (v & 1);
        v >>= 1;
      end
      if (i < r) begin
        tmp = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = tmp;
        tmp = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = tmp;
      end
    end
    for (int span = 2; span <= NPts; span <<= 1) begin
      for (int base = 0; base < NPts; base += span) begin
        for (int k = 0; k < span / 2; k++) begin
          a = base + k;
          b = a + span / 2;
          w = k * (NPts / span);
          xr = frame_re[b];
          xi = frame_im[b];
          // floor of x/2^17 after adding half, ties go up
          tr = (rom_re[w] * xr - rom_im[w] * xi + 65536) >>> 17;
          ti = (rom_re[w] * xi + rom_im[w] * xr + 65536) >>> 17;
          ar = frame_re[a];
          ai = frame_im[a];
          frame_re[b] = clip(ar - tr, rft_pkg::WordW);
          frame_im[b] = clip(ai - ti, rft_pkg::WordW);
          frame_re[a] = clip(ar + tr, rft_pkg::WordW);
          frame_im[a] = clip(ai + ti, rft_pkg::WordW);
        end
      end
    end
  endfunction

  function automatic void predict_bin(input rft_pkg::func_e f, input int idx, input longint sr,
                                      input longint si);
    bin_t e;
    e.re = '0;
    e.im = '0;
    case (f)
      rft_pkg::FUNC_STORE: begin
        frame_re[idx] = sr;
        frame_im[idx] = si;
        written[idx] = 1'b1;
        e.st = rft_pkg::STAT_STORED;
        bin_q.push_back(e);
      end
      rft_pkg::FUNC_XFORM: begin
        fft_frame();
        e.st = rft_pkg::STAT_DONE;
        bin_q.push_back(e);
      end
      rft_pkg::FUNC_READ: begin
        e.re = BinBits'(clip(frame_re[idx], rft_pkg::BinW));
        e.im = BinBits'(clip(frame_im[idx], rft_pkg::BinW));
        e.st = rft_pkg::STAT_READ;
        bin_q.push_back(e);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input rft_pkg::func_e f, input int idx,
                           input logic signed [15:0] sr, input logic signed [15:0] si);
    int gap, pick;
    pick = $urandom_range(0, 19);
    if (quiet_in != 0 || pick < 10) gap = 0;
    else if (pick < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.func        <= f;
    in_if.index       <= idx[rft_pkg::IdxW-1:0];
    in_if.sample_real <= sr;
    in_if.sample_imag <= si;
    do @(posedge clk_i); while (!in_if.ready);
    predict_bin(f, idx, sr, si);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return SmpBits'($urandom);
    endcase
  endfunction

  function automatic int rand_written_idx();
    int idx;
    do idx = $urandom_range(0, NPts - 1); while (!written[idx]);
    return idx;
  endfunction

  task automatic test_read_before_xform();
    send_item(rft_pkg::FUNC_STORE, 0, 16'sh8000, 16'sh7fff);
    send_item(rft_pkg::FUNC_STORE, NPts - 1, 16'sh7fff, 16'sh8000);
    send_item(rft_pkg::FUNC_STORE, 341, 16'sh5555, 16'shaaaa);
    send_item(rft_pkg::FUNC_STORE, 682, 16'shaaaa, 16'sh5555);
    send_item(rft_pkg::FUNC_READ, 0, '0, '0);
    send_item(rft_pkg::FUNC_NONE, 0, 16'sh7fff, 16'sh7fff);
    send_item(rft_pkg::FUNC_READ, NPts - 1, '0, '0);
    send_item(rft_pkg::FUNC_READ, 341, '0, '0);
    send_item(rft_pkg::FUNC_STORE, 341, 16'sh0000, 16'sh0000);
    send_item(rft_pkg::FUNC_READ, 341, '0, '0);
    send_item(rft_pkg::FUNC_READ, 682, '0, '0);
  endtask

  task automatic test_fill_and_xform();
    quiet_in = 1;
    for (int i = 0; i < NPts; i++) begin
      if (i == 0 || i == 341 || i == 682 || i == NPts - 1) continue;
      if (i == 512) quiet_in = 0;
      send_item(rft_pkg::FUNC_STORE, i, rand_sample(), rand_sample());
    end
    send_item(rft_pkg::FUNC_XFORM, 0, '0, '0);
    send_item(rft_pkg::FUNC_READ, 0, '0, '0);
    send_item(rft_pkg::FUNC_READ, NPts / 2, '0, '0);
    send_item(rft_pkg::FUNC_READ, NPts - 1, '0, '0);
  endtask

  task automatic test_full_scale_growth();
    // full-scale sample over the earlier frame, pushed through repeated transforms
    send_item(rft_pkg::FUNC_STORE, 0, 16'sh7fff, 16'sh8000);
    send_item(rft_pkg::FUNC_XFORM, 0, '0, '0);
    send_item(rft_pkg::FUNC_XFORM, 0, '0, '0);
    send_item(rft_pkg::FUNC_READ, 0, '0, '0);
    send_item(rft_pkg::FUNC_READ, 1, '0, '0);
    send_item(rft_pkg::FUNC_XFORM, 0, '0, '0);
    for (int i = 0; i < 6; i++) begin
      send_item(rft_pkg::FUNC_READ, $urandom_range(0, NPts - 1), '0, '0);
    end
  endtask

  task automatic test_random_traffic();
    int pick, xforms;
    xforms = 0;
    for (int n = 0; n < 280; n++) begin
      if (n % 70 == 0) quiet_in = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (pick < 45) send_item(rft_pkg::FUNC_STORE, $urandom_range(0, NPts - 1), rand_sample(),
                               rand_sample());
      else if (pick < 93) send_item(rft_pkg::FUNC_READ, rand_written_idx(), '0, '0);
      else if (pick < 98 || xforms >= 4) begin
        send_item(rft_pkg::FUNC_NONE, $urandom, SmpBits'($urandom), SmpBits'($urandom));
      end else begin
        send_item(rft_pkg::FUNC_XFORM, $urandom, SmpBits'($urandom), SmpBits'($urandom));
        xforms++;
      end
    end
    quiet_in = 0;
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    bin_t e;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (bin_q.size() == 0) begin
          report_mismatch("unexpected result, status", -1, longint'(out_if.status));
        end else begin
          e = bin_q.pop_front();
          if (out_if.status !== e.st) begin
            report_mismatch("status", longint'(e.st), longint'(out_if.status));
          end
          if (out_if.bin_real !== e.re) report_mismatch("bin_real", e.re, out_if.bin_real);
          if (out_if.bin_imag !== e.im) report_mismatch("bin_imag", e.im, out_if.bin_imag);
        end
      end
      if (quiet_out > 0) begin
        quiet_out--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 199) == 0) begin
        quiet_out = $urandom_range(15, 60);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    quiet_in = 0;
    for (int i = 0; i < NPts; i++) begin
      frame_re[i] = 0;
      frame_im[i] = 0;
      written[i] = 1'b0;
    end
    build_twiddle_rom();
    rst_ni = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.func        <= rft_pkg::FUNC_STORE;
    in_if.index       <= '0;
    in_if.sample_real <= '0;
    in_if.sample_imag <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_read_before_xform();
    test_fill_and_xform();
    test_full_scale_growth();
    test_random_traffic();
    in_if.valid <= 1'b0;
    while (bin_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_err == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
